// ===== hdl/tlsf_pkg.sv =====
// Shared constants and types for the tail line start finder.
// No dependencies; the top level, tlsf_tracker and tlsf_out import this package.
`default_nettype none
package tlsf_pkg;
   localparam int LINE_SLOTS  = 64;
   localparam int OFFSET_BITS = 32;
   localparam int CFG_BITS    = 7;
   localparam int BYTE_BITS   = 8;
   localparam int SLOT_BITS   = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
   localparam int CNT_BITS    = $clog2(LINE_SLOTS + 1);
   localparam logic [CFG_BITS-1:0]  LINE_COUNT_RESET = CFG_BITS'(10);
   localparam logic [BYTE_BITS-1:0] NEWLINE_CODE     = BYTE_BITS'(10);

   typedef struct packed {
      logic                   valid;
      logic                   zero;
      logic                   fwd;
      logic [OFFSET_BITS-1:0] fwd_data;
   } rd_req_type;
endpackage
`default_nettype wire

// ===== hdl/tail_line_start_finder.sv =====
// Top level of the tail line start finder: config register, tracker, ring RAM, result stage.
// Depends on tlsf_pkg, tlsf_ram, tlsf_tracker and tlsf_out.
`default_nettype none
// Takes one byte transaction per cycle with no gaps of its own; ready drops only while
// a finished result waits in both the read-data stage and the output register. The
// start offsets of the last line_count lines are kept in a 64-entry ring RAM with a
// registered read; the result of an end transaction passes through the RAM read
// register and the output register before it appears on rsp. A byte whose line start
// is written in the same cycle as the end read is forwarded around the RAM. The user
// must write line_count through csr only while idle; the block does not enforce this.
// 0 acts as 1 and values above 64 act as 64. The offset counter saturates at all ones.
module tail_line_start_finder (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [7:0]                       req_tdata,  // data_byte
   input  wire logic                             req_tuser,  // byte_present
   input  wire logic                             req_tlast,  // end_of_stream
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [tlsf_pkg::OFFSET_BITS-1:0] rsp_tdata,  // start_offset
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [tlsf_pkg::CFG_BITS-1:0]    csr_data    // line_count
);
   import tlsf_pkg::*;

   logic [CFG_BITS-1:0]    line_count_ff;
   logic                   room;
   logic                   accept;
   logic                   wr_en;
   logic [SLOT_BITS-1:0]   wr_addr;
   logic [OFFSET_BITS-1:0] wr_data;
   logic                   rd_en;
   logic [SLOT_BITS-1:0]   rd_addr;
   logic [OFFSET_BITS-1:0] rd_data;
   rd_req_type             rd_req;

   assign csr_ready  = 1'b1;
   assign req_tready = room;
   assign accept     = req_tvalid && room;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff <= LINE_COUNT_RESET;
      end else if (csr_valid) begin
         line_count_ff <= csr_data;
      end
   end

   tlsf_tracker u_tracker (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_tdata),
      .byte_present  (req_tuser),
      .end_of_stream (req_tlast),
      .line_count    (line_count_ff),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_req        (rd_req)
   );

   tlsf_ram #(
      .WIDTH (OFFSET_BITS),
      .DEPTH (LINE_SLOTS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tlsf_out u_out (
      .clock      (clock),
      .reset      (reset),
      .rd_req     (rd_req),
      .rd_data    (rd_data),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule
`default_nettype wire

// ===== hdl/tlsf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module tlsf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== hdl/tlsf_tracker.sv =====
// Line start tracker: offset counter, ring pointers and ring write/read requests.
// Depends on tlsf_pkg.
`default_nettype none
module tlsf_tracker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             accept,
   input  wire logic [tlsf_pkg::BYTE_BITS-1:0]   data_byte,
   input  wire logic                             byte_present,
   input  wire logic                             end_of_stream,
   input  wire logic [tlsf_pkg::CFG_BITS-1:0]    line_count,
   output logic                                  wr_en,
   output logic      [tlsf_pkg::SLOT_BITS-1:0]   wr_addr,
   output logic      [tlsf_pkg::OFFSET_BITS-1:0] wr_data,
   output logic                                  rd_en,
   output logic      [tlsf_pkg::SLOT_BITS-1:0]   rd_addr,
   output tlsf_pkg::rd_req_type                  rd_req
);
   import tlsf_pkg::*;

   logic [CNT_BITS-1:0]    held_ff, held_in;
   logic [SLOT_BITS-1:0]   oldest_ff, oldest_in;
   logic                   at_start_ff, at_start_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [CNT_BITS-1:0]    n;
   logic [SLOT_BITS-1:0]   slot;
   logic [CNT_BITS-1:0]    slot_next;
   logic                   full;
   logic [SLOT_BITS-1:0]   ans_slot;

   always_comb begin
      if (line_count == '0) begin
         n = CNT_BITS'(1);
      end else if (int'(line_count) > LINE_SLOTS) begin
         n = CNT_BITS'(LINE_SLOTS);
      end else begin
         n = CNT_BITS'(line_count);
      end
   end

   always_comb begin
      held_in     = held_ff;
      oldest_in   = oldest_ff;
      at_start_in = at_start_ff;
      pos_in      = pos_ff;
      wr_en       = 1'b0;
      wr_addr     = SLOT_BITS'(held_ff);
      wr_data     = pos_ff;
      full        = held_ff >= n;
      slot        = (CNT_BITS'(oldest_ff) >= n) ? '0 : oldest_ff;
      slot_next   = CNT_BITS'(slot) + CNT_BITS'(1);
      if (byte_present) begin
         if (at_start_ff) begin
            wr_en = 1'b1;
            if (full) begin
               wr_addr   = slot;
               oldest_in = (slot_next >= n) ? '0 : SLOT_BITS'(slot_next);
            end else begin
               held_in = held_ff + CNT_BITS'(1);
            end
         end
         at_start_in = data_byte == NEWLINE_CODE;
         if (pos_ff != '1) begin
            pos_in = pos_ff + OFFSET_BITS'(1);
         end
      end
      wr_en = wr_en & accept;

      if (held_in >= n) begin
         ans_slot = (CNT_BITS'(oldest_in) >= n) ? '0 : oldest_in;
      end else begin
         ans_slot = '0;
      end
      rd_addr          = ans_slot;
      rd_en            = accept & end_of_stream;
      rd_req.valid     = rd_en;
      rd_req.zero      = held_in == '0;
      rd_req.fwd       = wr_en && (wr_addr == ans_slot);
      rd_req.fwd_data  = wr_data;

      if (end_of_stream) begin
         held_in     = '0;
         oldest_in   = '0;
         at_start_in = 1'b1;
         pos_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= '0;
         oldest_ff   <= '0;
         at_start_ff <= 1'b1;
         pos_ff      <= '0;
      end else if (accept) begin
         held_ff     <= held_in;
         oldest_ff   <= oldest_in;
         at_start_ff <= at_start_in;
         pos_ff      <= pos_in;
      end
   end

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      int'(held_ff) <= LINE_SLOTS)
      else $error("held count beyond ring size");
   a_wr_in_window: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> CNT_BITS'(wr_addr) < n)
      else $error("ring write outside active window");
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_stream |=> held_ff == '0 && pos_ff == '0 && at_start_ff)
      else $error("stream state not cleared after end");
   a_read_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> accept && end_of_stream)
      else $error("ring read without end transaction");
endmodule
`default_nettype wire

// ===== hdl/tlsf_out.sv =====
// Result stage: aligns ring read data with forwarding, then holds the result register.
// Depends on tlsf_pkg.
`default_nettype none
module tlsf_out (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  tlsf_pkg::rd_req_type                  rd_req,
   input  wire logic [tlsf_pkg::OFFSET_BITS-1:0] rd_data,
   output logic                                  room,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [tlsf_pkg::OFFSET_BITS-1:0] rsp_tdata
);
   import tlsf_pkg::*;

   logic                   s1_valid_ff;
   logic                   s1_zero_ff;
   logic                   s1_fwd_ff;
   logic [OFFSET_BITS-1:0] s1_fwd_data_ff;
   logic                   rsp_valid_ff;
   logic [OFFSET_BITS-1:0] rsp_data_ff;
   logic                   advance;
   logic [OFFSET_BITS-1:0] value;

   assign advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign room    = !s1_valid_ff || advance;
   assign value   = s1_zero_ff ? '0 : (s1_fwd_ff ? s1_fwd_data_ff : rd_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (room) begin
            s1_valid_ff <= rd_req.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (room) begin
         s1_zero_ff     <= rd_req.zero;
         s1_fwd_ff      <= rd_req.fwd;
         s1_fwd_data_ff <= rd_req.fwd_data;
      end
      if (advance) begin
         rsp_data_ff <= value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_no_req_when_full: assert property (@(posedge clock) disable iff (reset)
      rd_req.valid |-> room)
      else $error("read issued while result stage is full");
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_zero_ff) && $stable(s1_fwd_ff))
      else $error("pending result lost");
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result register not loaded");
endmodule
`default_nettype wire
